FILE: rtl/core/gbp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the gshare branch predictor.
package gbp_pkg;

   localparam int ADDRESS_WIDTH   = 20;
   localparam int OUT_COUNT_WIDTH = 32;
   localparam int CTR_WIDTH       = 2;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = 2;

   localparam logic [CTR_WIDTH-1:0] CTR_MIN       = 2'd0;
   localparam logic [CTR_WIDTH-1:0] CTR_MAX       = 2'd3;
   localparam logic [CTR_WIDTH-1:0] CTR_TAKEN_MIN = 2'd2;

   typedef logic [CTR_WIDTH-1:0] ctr_type;

   typedef struct packed {
      logic was_branch;
      logic predicted_taken;
      logic was_correct;
   } item_type;

   function automatic ctr_type ctr_update(input ctr_type c, input logic taken);
      ctr_type r;
      r = c;
      if (taken) begin
         if (c != CTR_MAX) r = c + ctr_type'(1);
      end else begin
         if (c != CTR_MIN) r = c - ctr_type'(1);
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/gshare_branch_predictor.sv
`timescale 1ns / 1ps
// Top level of the gshare branch predictor with 2-bit saturating counters.
// Takes one micro-op transaction per cycle while req_stall is low and presents one result
// transaction for each; results pass the stage-one register, the queue and the output
// register in that order. The rate is set by the counter table, which takes one read and
// one write per cycle: its read-modify-write is closed with a forwarding register for
// back-to-back hits on the same entry. After reset the table is cleared one entry per
// cycle, so req_stall stays high until every entry has been cleared. A four-entry queue
// lets the prediction front end and the statistics back end stall independently.
module gshare_branch_predictor #(
   parameter int INDEX_BITS = 20,
   parameter int COUNT_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [gbp_pkg::ADDRESS_WIDTH-1:0]      req_branch_address,
   input  logic                                   req_is_cond_branch,
   input  logic                                   req_taken,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_predicted_taken,
   output logic                                   rsp_was_correct,
   output logic                                   rsp_was_branch,
   output logic [gbp_pkg::OUT_COUNT_WIDTH-1:0]    rsp_microop_count,
   output logic [gbp_pkg::OUT_COUNT_WIDTH-1:0]    rsp_branch_count,
   output logic [gbp_pkg::OUT_COUNT_WIDTH-1:0]    rsp_correct_count,
   output logic [gbp_pkg::OUT_COUNT_WIDTH-1:0]    rsp_wrong_count
);

   logic              push_valid;
   gbp_pkg::item_type push_item;
   logic              queue_full;
   logic              pop;
   logic              pop_valid;
   gbp_pkg::item_type pop_item;

   gbp_front #(
      .INDEX_BITS(INDEX_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_branch_address(req_branch_address),
      .req_is_cond_branch(req_is_cond_branch),
      .req_taken         (req_taken),
      .push_valid        (push_valid),
      .push_item         (push_item),
      .queue_full        (queue_full)
   );

   gbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   gbp_back #(
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_item           (pop_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_predicted_taken(rsp_predicted_taken),
      .rsp_was_correct    (rsp_was_correct),
      .rsp_was_branch     (rsp_was_branch),
      .rsp_microop_count  (rsp_microop_count),
      .rsp_branch_count   (rsp_branch_count),
      .rsp_correct_count  (rsp_correct_count),
      .rsp_wrong_count    (rsp_wrong_count)
   );

endmodule

FILE: rtl/core/gbp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module gbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/gbp_front.sv
`timescale 1ns / 1ps
// Front end: accepts micro-ops, tracks history, predicts, updates the counter table and clears it after reset.
module gbp_front #(
   parameter int INDEX_BITS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [gbp_pkg::ADDRESS_WIDTH-1:0]    req_branch_address,
   input  logic                                 req_is_cond_branch,
   input  logic                                 req_taken,
   output logic                                 push_valid,
   output gbp_pkg::item_type                    push_item,
   input  logic                                 queue_full
);

   logic                    clear_ff, clear_in;
   logic [INDEX_BITS-1:0]   clear_addr_ff, clear_addr_in;
   logic [INDEX_BITS-1:0]   hist_ff, hist_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_branch_ff;
   logic                    s1_taken_ff;
   logic [INDEX_BITS-1:0]   s1_idx_ff;
   logic                    fwd_hit_ff;
   gbp_pkg::ctr_type        fwd_data_ff;

   logic                    accept;
   logic                    s1_advance;
   logic [INDEX_BITS-1:0]   rd_addr;
   gbp_pkg::ctr_type        rd_data;
   gbp_pkg::ctr_type        ctr_cur;
   gbp_pkg::ctr_type        ctr_next;
   logic                    s1_write;
   logic                    wr_en;
   logic [INDEX_BITS-1:0]   wr_addr;
   gbp_pkg::ctr_type        wr_data;
   logic                    pred;

   assign req_stall  = clear_ff || (s1_valid_ff && queue_full);
   assign accept     = req_valid && !req_stall;
   assign s1_advance = s1_valid_ff && !queue_full;
   assign rd_addr    = INDEX_BITS'(req_branch_address) ^ hist_ff;

   assign ctr_cur  = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign pred     = ctr_cur >= gbp_pkg::CTR_TAKEN_MIN;
   assign ctr_next = gbp_pkg::ctr_update(ctr_cur, s1_taken_ff);
   assign s1_write = s1_advance && s1_branch_ff;

   assign wr_en   = clear_ff || s1_write;
   assign wr_addr = clear_ff ? clear_addr_ff : s1_idx_ff;
   assign wr_data = clear_ff ? gbp_pkg::CTR_MIN : ctr_next;

   assign push_valid                = s1_advance;
   assign push_item.was_branch      = s1_branch_ff;
   assign push_item.predicted_taken = s1_branch_ff && pred;
   assign push_item.was_correct     = s1_branch_ff && (pred == s1_taken_ff);

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + INDEX_BITS'(1);
         if (clear_addr_ff == {INDEX_BITS{1'b1}}) clear_in = 1'b0;
      end
      hist_in = hist_ff;
      if (accept && req_is_cond_branch) begin
         hist_in = {hist_ff[INDEX_BITS-2:0], ~req_taken};
      end
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         hist_ff       <= '1;
         s1_valid_ff   <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         hist_ff       <= hist_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   // register stage one and capture the write that lands on the same edge as this read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_branch_ff <= req_is_cond_branch;
         s1_taken_ff  <= req_taken;
         s1_idx_ff    <= rd_addr;
         fwd_hit_ff   <= s1_write && (s1_idx_ff == rd_addr);
         fwd_data_ff  <= ctr_next;
      end
   end

   gbp_ram #(
      .WIDTH(gbp_pkg::CTR_WIDTH),
      .DEPTH(2 ** INDEX_BITS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

endmodule

FILE: rtl/core/gbp_queue.sv
`timescale 1ns / 1ps
// Small queue between the predictor front end and the statistics back end.
module gbp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  gbp_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output gbp_pkg::item_type pop_item
);

   gbp_pkg::item_type                   entry_ff [gbp_pkg::QUEUE_DEPTH];
   logic [gbp_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [gbp_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [gbp_pkg::QUEUE_PTR_BITS:0]    count_ff, count_in;
   logic                                do_pop;

   assign full      = count_ff == (gbp_pkg::QUEUE_PTR_BITS + 1)'(gbp_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + gbp_pkg::QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + gbp_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + (gbp_pkg::QUEUE_PTR_BITS + 1)'(1);
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - (gbp_pkg::QUEUE_PTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

FILE: rtl/core/gbp_back.sv
`timescale 1ns / 1ps
// Back end: running saturating counts and the result output register.
module gbp_back #(
   parameter int COUNT_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   pop_valid,
   input  gbp_pkg::item_type                      pop_item,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_predicted_taken,
   output logic                                   rsp_was_correct,
   output logic                                   rsp_was_branch,
   output logic [gbp_pkg::OUT_COUNT_WIDTH-1:0]    rsp_microop_count,
   output logic [gbp_pkg::OUT_COUNT_WIDTH-1:0]    rsp_branch_count,
   output logic [gbp_pkg::OUT_COUNT_WIDTH-1:0]    rsp_correct_count,
   output logic [gbp_pkg::OUT_COUNT_WIDTH-1:0]    rsp_wrong_count
);

   logic                   rsp_valid_ff, rsp_valid_in;
   gbp_pkg::item_type      item_ff;
   logic [COUNT_BITS-1:0]  microops_ff, microops_in;
   logic [COUNT_BITS-1:0]  branches_ff, branches_in;
   logic [COUNT_BITS-1:0]  hits_ff, hits_in;
   logic [COUNT_BITS-1:0]  misses_ff, misses_in;
   logic                   out_free;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v,
                                                     input logic en);
      logic [COUNT_BITS-1:0] r;
      r = v;
      if (en && (v != {COUNT_BITS{1'b1}})) r = v + COUNT_BITS'(1);
      return r;
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = pop_valid && out_free;

   always_comb begin
      microops_in  = sat_inc(microops_ff, pop);
      branches_in  = sat_inc(branches_ff, pop && pop_item.was_branch);
      hits_in      = sat_inc(hits_ff, pop && pop_item.was_branch && pop_item.was_correct);
      misses_in    = sat_inc(misses_ff, pop && pop_item.was_branch && !pop_item.was_correct);
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         microops_ff  <= '0;
         branches_ff  <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         microops_ff  <= microops_in;
         branches_ff  <= branches_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) item_ff <= pop_item;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_taken = item_ff.predicted_taken;
   assign rsp_was_correct     = item_ff.was_correct;
   assign rsp_was_branch      = item_ff.was_branch;
   assign rsp_microop_count   = gbp_pkg::OUT_COUNT_WIDTH'(microops_ff);
   assign rsp_branch_count    = gbp_pkg::OUT_COUNT_WIDTH'(branches_ff);
   assign rsp_correct_count   = gbp_pkg::OUT_COUNT_WIDTH'(hits_ff);
   assign rsp_wrong_count     = gbp_pkg::OUT_COUNT_WIDTH'(misses_ff);

endmodule
